// File: rtl/ase_pkg.sv
// ase_pkg: shared sizes, types and state codes of the ascending sort engine
// no dependencies; used by ase_cell, ascending_sort_engine and the testbench
package ase_pkg;

  // capacity of the sort chain and width of one value
  localparam int unsigned Depth      = 64;
  localparam int unsigned ValueWidth = 32;

  // element counter holds 0 .. Depth
  localparam int unsigned CountWidth = $clog2(Depth + 1);

  // stream word width: value rounded up to whole bytes
  localparam int unsigned TdataWidth = ((ValueWidth + 7) / 8) * 8;

  typedef logic signed [ValueWidth-1:0] value_t;
  typedef logic [CountWidth-1:0]        count_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert; // place the new value in sorted position
    logic shift;  // move every entry one cell toward the output
  } cell_ctrl_t;

  // controller states, one-hot
  typedef enum logic [1:0] {
    StLoad  = 2'b01,
    StDrain = 2'b10
  } state_e;

endpackage

// File: rtl/ase_cell.sv
// ase_cell: one slot of the sorted insertion chain
// depends on ase_pkg; instantiated in a row by ascending_sort_engine
module ase_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ase_pkg::cell_ctrl_t ctrl_i,
  input  ase_pkg::value_t     new_value_i,
  // neighbor toward the output (smaller values)
  input  logic                left_valid_i,
  input  logic                left_gt_i,
  input  ase_pkg::value_t     left_value_i,
  // neighbor away from the output (larger values)
  input  logic                right_valid_i,
  input  ase_pkg::value_t     right_value_i,
  // own state, seen by both neighbors
  output logic                valid_o,
  output logic                gt_o,
  output ase_pkg::value_t     value_o
);

  logic            valid_q, valid_d;
  ase_pkg::value_t value_q, value_d;
  logic            take_new;

  // stored entry is strictly larger than the value being inserted
  assign gt_o = valid_q && (value_q > new_value_i);

  // new value lands in the first cell that is larger or empty
  assign take_new = left_valid_i && !left_gt_i && (gt_o || !valid_q);

  // next entry: drain shift, insertion shift, insertion, or hold
  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (ctrl_i.shift) begin
      valid_d = right_valid_i;
      value_d = right_value_i;
    end else if (ctrl_i.insert) begin
      if (left_gt_i) begin
        valid_d = 1'b1;
        value_d = left_value_i;
      end else if (take_new) begin
        valid_d = 1'b1;
        value_d = new_value_i;
      end
    end
  end

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // entry value, no reset needed
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign valid_o = valid_q;
  assign value_o = value_q;

endmodule

// File: rtl/ascending_sort_engine.sv
// ascending_sort_engine: top level, a row of ase_cell slots kept in sorted order
// depends on ase_pkg and ase_cell
//
//  channel   | dir | handshake                    | payload
//  ----------+-----+------------------------------+----------------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata: value_in, tlast: last_in
//  m_axis    | out | m_axis_tvalid / m_axis_tready | tdata: value_out, tlast: last_out,
//            |     |                              | tuser: overflow
//
// loading takes one word per cycle: every cell compares the new word at once and
// the chain opens a slot at the sorted position in that cycle.
// the word with tlast closes the set; the chain then shifts toward the output
// register one entry per cycle while the output register is free to take it.
// no input word is taken while a set drains; a stalled output holds the chain.
// reset empties the chain and the counters at once, no clearing pass.
module ascending_sort_engine (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [ase_pkg::TdataWidth-1:0]   s_axis_tdata,  // [ValueWidth-1:0] value_in
  input  logic                             s_axis_tlast,  // last_in
  // output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [ase_pkg::TdataWidth-1:0]   m_axis_tdata,  // [ValueWidth-1:0] value_out
  output logic                             m_axis_tlast,  // last_out
  output logic                             m_axis_tuser   // [0] overflow
);

  localparam int unsigned N = ase_pkg::Depth;

  ase_pkg::state_e   state_q, state_d;
  ase_pkg::count_t   count_q, count_d;
  logic              drop_q, drop_d;
  logic              out_valid_q, out_valid_d;
  logic              out_last_q, out_last_d;
  logic              out_ovf_q, out_ovf_d;
  ase_pkg::value_t   out_value_q, out_value_d;

  ase_pkg::cell_ctrl_t ctrl;
  ase_pkg::value_t     new_value;
  logic                in_fire;
  logic                full;
  logic                pop;

  logic            cell_valid [N];
  logic            cell_gt    [N];
  ase_pkg::value_t cell_value [N];

  assign new_value     = s_axis_tdata[ase_pkg::ValueWidth-1:0];
  assign s_axis_tready = (state_q == ase_pkg::StLoad);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign full          = (count_q == ase_pkg::count_t'(N));

  // drain moves the head of the chain into a free output register
  assign pop = (state_q == ase_pkg::StDrain) && (count_q != '0) &&
               (!out_valid_q || m_axis_tready);

  assign ctrl.insert = in_fire && !full;
  assign ctrl.shift  = pop;

  // row of sorting cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic            lv, lg, rv;
    ase_pkg::value_t lval, rval;
    if (i == 0) begin : g_head
      assign lv   = 1'b1;
      assign lg   = 1'b0;
      assign lval = '0;
    end else begin : g_body
      assign lv   = cell_valid[i-1];
      assign lg   = cell_gt[i-1];
      assign lval = cell_value[i-1];
    end
    if (i == N - 1) begin : g_tail
      assign rv   = 1'b0;
      assign rval = '0;
    end else begin : g_inner
      assign rv   = cell_valid[i+1];
      assign rval = cell_value[i+1];
    end
    ase_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_value_i  (new_value),
      .left_valid_i (lv),
      .left_gt_i    (lg),
      .left_value_i (lval),
      .right_valid_i(rv),
      .right_value_i(rval),
      .valid_o      (cell_valid[i]),
      .gt_o         (cell_gt[i]),
      .value_o      (cell_value[i])
    );
  end

  // load / drain sequencing, count and overflow tracking, output register
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    drop_d      = drop_q;
    out_valid_d = out_valid_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    out_value_d = out_value_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ase_pkg::StLoad: begin
        if (in_fire) begin
          if (full) begin
            drop_d = 1'b1;
          end else begin
            count_d = count_q + ase_pkg::count_t'(1);
          end
          if (s_axis_tlast) begin
            state_d = ase_pkg::StDrain;
          end
        end
      end
      ase_pkg::StDrain: begin
        if (pop) begin
          out_valid_d = 1'b1;
          out_value_d = cell_value[0];
          out_last_d  = (count_q == ase_pkg::count_t'(1));
          out_ovf_d   = drop_q;
          count_d     = count_q - ase_pkg::count_t'(1);
          if (count_q == ase_pkg::count_t'(1)) begin
            state_d = ase_pkg::StLoad;
            drop_d  = 1'b0;
          end
        end
      end
      default: begin
        state_d = ase_pkg::StLoad;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ase_pkg::StLoad;
      count_q     <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = ase_pkg::TdataWidth'($unsigned(out_value_q));
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_ovf_q;

endmodule

// File: verif/testbench.sv
// testbench: self-checking bench for ascending_sort_engine, sets of signed words
// in, the same words back in ascending order; depends on ase_pkg and the engine rtl
// a queued driver and a stalling sink run against an in-bench insertion-sort predictor
module testbench;
  import ase_pkg::*;

  localparam value_t      ValMin     = {1'b1, {(ValueWidth-1){1'b0}}};
  localparam value_t      ValMax     = ~ValMin;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned TailCycles = 20;

  // one word waiting to be sent
  typedef struct {
    value_t      value;
    logic        closes;
    bit          wait_empty;  // hold this word until every sorted word is back
    int unsigned gap_after;
  } sort_word_t;

  // one sorted word the engine owes us
  typedef struct {
    value_t value;
    logic   tail;
    logic   ovf;
  } sorted_word_t;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [TdataWidth-1:0] s_axis_tdata = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [TdataWidth-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  m_axis_tuser;

  sort_word_t   words_to_send[$];
  sorted_word_t sorted_expect[$];

  // predictor state: a sorted copy of the chain
  value_t      chain_model[Depth];
  int unsigned chain_fill;
  bit          chain_dropped;

  int unsigned words_queued;
  int unsigned words_taken;
  int unsigned sets_closed;
  int unsigned sets_overflowed;
  int unsigned results_seen;
  int unsigned order_errors;
  int unsigned quiet_cycles;
  int unsigned gap_left;
  int unsigned stall_left;
  bit          calm_sender;
  bit          calm_sink;
  bit          hold_for_drain;

  ascending_sort_engine u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // mostly short pauses, now and then a long one
  function automatic int unsigned pick_pause();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return 0;
    if (roll < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // mix of full-range, clustered (duplicates) and edge values
  function automatic value_t rand_value();
    case ($urandom_range(0, 5))
      0, 1, 2: return value_t'($urandom);
      3:       return value_t'(int'($urandom_range(0, 8)) - 4);
      4: begin
        case ($urandom_range(0, 3))
          0:       return ValMin;
          1:       return ValMax;
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return $urandom_range(0, 1) ? ValMin + value_t'($urandom_range(0, 3))
                                           : ValMax - value_t'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic void push_word(value_t v, logic closes);
    sort_word_t w;
    w.value      = v;
    w.closes     = closes;
    w.wait_empty = hold_for_drain;
    w.gap_after  = calm_sender ? 0 : pick_pause();
    hold_for_drain = 1'b0;
    words_to_send.push_back(w);
    words_queued++;
  endfunction

  function automatic void push_set(int unsigned n);
    for (int unsigned i = 0; i < n; i++) push_word(rand_value(), i == n - 1);
  endfunction

  // insert one accepted word; on the closing word emit the whole sorted set
  function automatic void absorb_value(value_t v, logic closes);
    int unsigned pos;
    sorted_word_t r;
    if (chain_fill < Depth) begin
      pos = chain_fill;
      while (pos > 0 && chain_model[pos-1] > v) begin
        chain_model[pos] = chain_model[pos-1];
        pos--;
      end
      chain_model[pos] = v;
      chain_fill++;
    end else begin
      chain_dropped = 1'b1;
    end
    if (closes) begin
      for (int unsigned k = 0; k < chain_fill; k++) begin
        r.value = chain_model[k];
        r.tail  = (k + 1 == chain_fill);
        r.ovf   = chain_dropped;
        sorted_expect.push_back(r);
      end
      sets_closed++;
      if (chain_dropped) sets_overflowed++;
      chain_fill    = 0;
      chain_dropped = 1'b0;
    end
  endfunction

  // driver: presents queued words, keeps a word steady until it is taken
  always @(posedge clk_i or negedge rst_ni) begin
    sort_word_t            nxt;
    logic [TdataWidth-1:0] word;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      gap_left      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_value(s_axis_tdata[ValueWidth-1:0], s_axis_tlast);
        words_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left      <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (words_to_send.size() != 0 &&
                     (!words_to_send[0].wait_empty || sorted_expect.size() == 0)) begin
          nxt  = words_to_send.pop_front();
          word = '0;
          word[ValueWidth-1:0] = nxt.value;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= word;
          s_axis_tlast  <= nxt.closes;
          gap_left      <= nxt.gap_after;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compares each sorted word with the oldest expectation, stalls at random
  always @(posedge clk_i or negedge rst_ni) begin
    sorted_word_t want;
    value_t       got;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[ValueWidth-1:0];
        results_seen++;
        if ($urandom_range(0, 49) == 0) calm_sink = ~calm_sink;
        if (sorted_expect.size() == 0) begin
          order_errors++;
          if (order_errors <= 10)
            $display("ERROR: unexpected sorted word %0d last=%b ovf=%b",
                     got, m_axis_tlast, m_axis_tuser);
        end else begin
          want = sorted_expect.pop_front();
          if (got !== want.value || m_axis_tlast !== want.tail ||
              m_axis_tuser !== want.ovf) begin
            order_errors++;
            if (order_errors <= 10)
              $display("ERROR: word %0d: expected %0d last=%b ovf=%b, got %0d last=%b ovf=%b",
                       results_seen, want.value, want.tail, want.ovf,
                       got, m_axis_tlast, m_axis_tuser);
          end
        end
      end
      if (stall_left != 0) begin
        stall_left    <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm_sink) stall_left <= pick_pause();
      end
    end
  end

  // watchdog: too long without any word moving on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("ERROR: no word moved for %0d cycles", QuietLimit);
      $display("Some tests failed");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int unsigned set_no;
    int unsigned n;
    chain_fill      = 0;
    chain_dropped   = 1'b0;
    words_queued    = 0;
    words_taken     = 0;
    sets_closed     = 0;
    sets_overflowed = 0;
    results_seen    = 0;
    order_errors    = 0;
    quiet_cycles    = 0;
    calm_sender     = 1'b0;
    calm_sink       = 1'b0;
    hold_for_drain  = 1'b0;

    // directed: single word, extremes, duplicates, reverse-sorted and presorted runs
    push_word(ValMax, 1'b1);
    push_word(ValMin, 1'b0);
    push_word(ValMax, 1'b0);
    push_word('0, 1'b0);
    push_word('1, 1'b0);
    push_word(value_t'(1), 1'b1);
    push_word(value_t'(5), 1'b0);
    push_word(value_t'(-5), 1'b0);
    push_word(value_t'(5), 1'b0);
    push_word(value_t'(5), 1'b1);
    calm_sender = 1'b1;
    push_word(value_t'(3), 1'b0);
    push_word(value_t'(2), 1'b0);
    push_word(value_t'(1), 1'b0);
    push_word(value_t'(0), 1'b1);
    push_word(value_t'(-3), 1'b0);
    push_word(value_t'(-2), 1'b0);
    push_word(value_t'(-1), 1'b1);
    calm_sender    = 1'b0;
    hold_for_drain = 1'b1;
    push_word(ValMax, 1'b0);
    push_word(ValMin, 1'b1);

    // random sets, mostly small; one exactly full and one that overflows
    set_no         = 0;
    hold_for_drain = 1'b1;
    while (words_queued < 160) begin
      calm_sender = ($urandom_range(0, 9) < 3);
      if ($urandom_range(0, 9) == 0) hold_for_drain = 1'b1;
      if (set_no == 1) begin
        push_set(Depth);
      end else if (set_no == 3) begin
        push_set(Depth + 2);
      end else begin
        n = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(9, 20);
        push_set(n);
      end
      set_no++;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (words_taken < words_queued) @(negedge clk_i);
    while (sorted_expect.size() != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);

    $display("Summary: %0d words in %0d sets (%0d overflowed), %0d sorted words checked",
             words_taken, sets_closed, sets_overflowed, results_seen);
    $display("Summary: %0d mismatches", order_errors);
    if (order_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
